>>> src/rotation_matrix_to_euler_angles_top_macros.svh
// Assertion macros for the rotation-matrix-to-Euler block.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_TOP_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define RME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition holds in the cycle right after a trigger condition.
`define RME_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> src/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants and CORDIC angle table for the rotation-matrix-to-Euler block.
// ----------------------------------------------------------------------------
`default_nettype none
package rme_pkg;

  localparam int IN_FRAC_BITS_DEF    = 14;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int FIELD_W             = 16;
  localparam int MARGIN_W            = 8;
  localparam int OP_SHIFT            = 24;
  localparam int ANG_W               = 64;

  localparam logic signed [ANG_W-1:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q60 = 64'sh1921FB54442D1847;

  // atan(2^-i) in Q62 by truncated power series (pi/4 from PI_Q60 for i = 0), then rounded to Q60
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] acc;
    logic [ANG_W-1:0]        term;
    int                      e;
    acc = '0;
    if (i == 0) begin
      return (PI_Q60 + 64'sd2) >>> 2;
    end
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - $signed(term);
        else            acc = acc + $signed(term);
      end
    end
    return (acc + 64'sd2) >>> 2;
  endfunction

endpackage
`default_nettype wire

>>> src/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC atan2, Q60 angle out, one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none
module rme_cordic #(
  parameter int STEPS = rme_pkg::CORDIC_STEPS_DEF,
  parameter int OP_W  = 34
) (
  input  wire                           clk,
  input  wire                           en,
  input  wire logic signed [OP_W-1:0]   y_in,
  input  wire logic signed [OP_W-1:0]   x_in,
  output logic signed [rme_pkg::ANG_W-1:0] z_out
);
  import rme_pkg::*;

  // operands are 34-bit ints shifted by 24; growth needs a few more bits
  localparam int W = OP_W + OP_SHIFT + 3;

  logic signed [W-1:0]     x_r [STEPS+1];
  logic signed [W-1:0]     y_r [STEPS+1];
  logic signed [ANG_W-1:0] z_r [STEPS+1];
  logic                    zero_r [STEPS+1];

  logic signed [W-1:0]     x0, y0;
  logic signed [ANG_W-1:0] z0;

  always_comb begin
    x0 = W'(x_in) <<< OP_SHIFT;
    y0 = W'(y_in) <<< OP_SHIFT;
    z0 = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0 = W'(y_in) <<< OP_SHIFT;
        y0 = -(W'(x_in) <<< OP_SHIFT);
        z0 = HALF_PI_Q60;
      end else begin
        x0 = -(W'(y_in) <<< OP_SHIFT);
        y0 = W'(x_in) <<< OP_SHIFT;
        z0 = -HALF_PI_Q60;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_step(i);
    localparam int SH = (i < W) ? i : W - 1;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> SH);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> SH);
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> SH);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> SH);
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
      end
    end
  end

  assign z_out = zero_r[STEPS] ? '0 : z_r[STEPS];

endmodule
`default_nettype wire

>>> src/rotation_matrix_to_euler_angles_top.sv
// Pipeline: decode register, 32 root stages, operand register, CORDIC_STEPS+1
//   CORDIC stages (all three side by side), select register, CORDIC_STEPS pad
//   stages and the output register.
// Throughput: one request per cycle; the whole pipe advances unless the
//   output register is full and not taken.
// Reset: rst_n synchronous active low clears valid bits and margin_r.
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_top
// Streams rotation matrices in, Euler XYZ angles out, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_euler_angles_top #(
  parameter int IN_FRAC_BITS    = rme_pkg::IN_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = rme_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = rme_pkg::CORDIC_STEPS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // normal_x, normal_y, normal_z, orient_x, approach_x, approach_y, approach_z
  input  wire  [111:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // angle_x, angle_y, angle_z
  output logic [47:0] out_tdata
);
  import rme_pkg::*;

  localparam int  G      = 31 - IN_FRAC_BITS;
  localparam int  OP_W   = 34;
  localparam int  SQ_N   = 32;            // root bits: result < 2^32
  localparam int  D1     = SQ_N + 2;      // front: decode + root steps + reg
  localparam int  CL     = CORDIC_STEPS + 1;
  localparam int  LAT    = D1 + 2 * CL + 1;
  localparam int  SH_OUT = 60 - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] HALF_R = ANG_W'(1) <<< (SH_OUT - 1);

  typedef logic signed [FIELD_W-1:0] fld_t;
  typedef logic signed [OP_W-1:0]    op_t;
  typedef logic signed [ANG_W-1:0]   ang_t;

  // per-item decode travelling along the pipe
  typedef struct packed {
    logic [1:0] pole;      // 0 none, 1 negative, 2 positive
    logic       flip;
    op_t        s;
    op_t        rx_y, rx_x, rz_y, rz_x;
  } ctl_t;

  localparam logic [1:0] POLE_NONE = 2'd0;
  localparam logic [1:0] POLE_NEG  = 2'd1;
  localparam logic [1:0] POLE_POS  = 2'd2;

  logic [MARGIN_W-1:0] margin_r;
  logic                en;
  logic                out_v_r;
  logic [LAT-1:0]      vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) margin_r <= '0;
    else if (cfg_we) margin_r <= cfg_wdata;
  end

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // ---------------- decode stage
  fld_t nx, ny, nz, ox, ax, ay, az;
  assign nx = in_tdata[15:0];
  assign ny = in_tdata[31:16];
  assign nz = in_tdata[47:32];
  assign ox = in_tdata[63:48];
  assign ax = in_tdata[79:64];
  assign ay = in_tdata[95:80];
  assign az = in_tdata[111:96];

  ctl_t ctl_nxt;
  logic [63:0] d_nxt;
  always_comb begin
    logic signed [OP_W-1:0] one, m, aax, aay;
    logic signed [63:0]     dd;
    one = OP_W'(1) <<< IN_FRAC_BITS;
    m   = OP_W'(margin_r);
    aax = (ax < 0) ? -OP_W'(ax) : OP_W'(ax);
    aay = (ay < 0) ? -OP_W'(ay) : OP_W'(ay);
    ctl_nxt      = '0;
    ctl_nxt.s    = OP_W'(ax) <<< G;
    dd           = 64'(one) * 64'(one) - 64'(ax) * 64'(ax);
    d_nxt        = 64'(dd) << (2 * G);
    if (OP_W'(ax) <= -one + m) begin
      ctl_nxt.pole = POLE_NEG;
      ctl_nxt.rz_y = OP_W'(ny);
      ctl_nxt.rz_x = OP_W'(nz);
    end else if (OP_W'(ax) >= one - m) begin
      ctl_nxt.pole = POLE_POS;
      ctl_nxt.rz_y = OP_W'(ny);
      ctl_nxt.rz_x = -OP_W'(nz);
    end else if (az < 0 && nx < 0 && (aax > m || aay > m)) begin
      ctl_nxt.flip = 1'b1;
      ctl_nxt.rx_y = OP_W'(ay);
      ctl_nxt.rx_x = -OP_W'(az);
      ctl_nxt.rz_y = OP_W'(ox);
      ctl_nxt.rz_x = -OP_W'(nx);
    end else begin
      ctl_nxt.rx_y = -OP_W'(ay);
      ctl_nxt.rx_x = OP_W'(az);
      ctl_nxt.rz_y = -OP_W'(ox);
      ctl_nxt.rz_x = OP_W'(nx);
    end
  end

  // ---------------- square root, one result bit per stage
  ctl_t        ctl_r [SQ_N+1];
  logic [63:0] rem_r [SQ_N+1];
  logic [31:0] root_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0]  <= ctl_nxt;
      rem_r[0]  <= d_nxt;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam int B = SQ_N - 1 - k;
    logic [63:0] trial;
    assign trial = ({32'd0, root_r[k]} << (B + 1)) | (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k+1] <= ctl_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial;
          root_r[k+1] <= root_r[k] | (32'd1 << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  // ---------------- CORDIC stage 1: Ry and Rx side by side; Rz as well
  ctl_t ctl_a_r;
  op_t  c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_a_r <= ctl_r[SQ_N];
      c_r     <= OP_W'(root_r[SQ_N]);
    end
  end

  ang_t ry_z, rx_z, rz_z;
  rme_cordic #(.STEPS(CORDIC_STEPS), .OP_W(OP_W)) u_ry (
    .clk(clk), .en(en), .y_in(ctl_a_r.s), .x_in(c_r), .z_out(ry_z));
  rme_cordic #(.STEPS(CORDIC_STEPS), .OP_W(OP_W)) u_rx (
    .clk(clk), .en(en), .y_in(ctl_a_r.rx_y), .x_in(ctl_a_r.rx_x), .z_out(rx_z));
  rme_cordic #(.STEPS(CORDIC_STEPS), .OP_W(OP_W)) u_rz (
    .clk(clk), .en(en), .y_in(ctl_a_r.rz_y), .x_in(ctl_a_r.rz_x), .z_out(rz_z));

  // control delay matching the CORDIC depth
  ctl_t ctl_d_r [CL];
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_d_r[0] <= ctl_a_r;
      for (int i = 1; i < CL; i++) ctl_d_r[i] <= ctl_d_r[i-1];
    end
  end

  // ---------------- select and reflect, registered
  ctl_t ctl_e;
  ang_t rx_s_r, ry_s_r, rz_s_r;
  assign ctl_e = ctl_d_r[CL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      rz_s_r <= rz_z;
      if (ctl_e.pole == POLE_NEG) begin
        rx_s_r <= '0;
        ry_s_r <= -HALF_PI_Q60;
      end else if (ctl_e.pole == POLE_POS) begin
        rx_s_r <= '0;
        ry_s_r <= HALF_PI_Q60;
      end else begin
        rx_s_r <= rx_z;
        if (!ctl_e.flip)   ry_s_r <= ry_z;
        else if (ry_z >= 0) ry_s_r <= PI_Q60 - ry_z;
        else               ry_s_r <= -PI_Q60 - ry_z;
      end
    end
  end

  // pad stages to the declared latency
  localparam int PAD = LAT - (D1 + CL + 2);
  ang_t px_r [PAD+1], py_r [PAD+1], pz_r [PAD+1];
  assign px_r[0] = rx_s_r;
  assign py_r[0] = ry_s_r;
  assign pz_r[0] = rz_s_r;
  for (genvar p = 0; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        px_r[p+1] <= px_r[p];
        py_r[p+1] <= py_r[p];
        pz_r[p+1] <= pz_r[p];
      end
    end
  end

  function automatic logic [FIELD_W-1:0] finish(input ang_t v);
    ang_t c, r;
    c = v;
    if (c > PI_Q60)  c = PI_Q60;
    if (c < -PI_Q60) c = -PI_Q60;
    if (c >= 0) r = (c + HALF_R) >>> SH_OUT;
    else        r = -((-c + HALF_R) >>> SH_OUT);
    return r[FIELD_W-1:0];
  endfunction

  logic [47:0] out_d_r;
  always_ff @(posedge clk) begin
    if (en) out_d_r <= {finish(pz_r[PAD]), finish(py_r[PAD]), finish(px_r[PAD])};
  end
  assign out_tdata = out_d_r;

  // valid pipe; last bit is the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end
  assign out_v_r    = vld_r[LAT-1];
  assign out_tvalid = out_v_r;

endmodule
`default_nettype wire

>>> src/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks for the rotation-matrix-to-Euler block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotation_matrix_to_euler_angles_top_macros.svh"
module rme_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [47:0] out_tdata
);
  `RME_ASSERT(a_ready_follows_out, in_tready == (!out_tvalid || out_tready), "ready mismatch")
  `RME_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata) && out_tvalid,
    "stalled result changed")
  `RME_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid, "valid after reset")
  `RME_ASSERT(a_range_x, $signed(out_tdata[15:0]) <= 16'sd25736 &&
    $signed(out_tdata[15:0]) >= -16'sd25736 || !out_tvalid, "angle_x out of range")
endmodule

bind rotation_matrix_to_euler_angles_top rme_checker u_rme_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire
